// File: rtl/grod_pkg.sv
`default_nettype none

package grod_pkg;

	// Pixel and result field widths.
	localparam int unsigned PIX_W   = 8;
	localparam int unsigned WIDTH_W = 11;
	localparam int unsigned TH_W    = 64;
	localparam int unsigned PROD_W  = 24;

	// Configuration register indexes.
	localparam int unsigned CFG_IDX_W = 2;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_IMAGE_WIDTH = 2'd0;
	localparam cfg_idx_t REG_TH_ROWS_0_1 = 2'd1;
	localparam cfg_idx_t REG_TH_ROWS_2_3 = 2'd2;

	// Luma weights in Q16, each the floor of weight * 65536.
	localparam logic [15:0] WEIGHT_BLUE  = 16'd7471;
	localparam logic [15:0] WEIGHT_GREEN = 16'd38469;
	localparam logic [15:0] WEIGHT_RED   = 16'd19595;

	// Register values after reset.
	localparam logic [WIDTH_W-1:0] RESET_WIDTH = 11'd1024;
	localparam logic [TH_W-1:0]    RESET_TH01  = 64'h64F0_50D0_B030_9010;
	localparam logic [TH_W-1:0]    RESET_TH23  = 64'h60E0_80FF_A020_C040;

	localparam logic [PIX_W-1:0] DITHER_LOW  = 8'd0;
	localparam logic [PIX_W-1:0] DITHER_HIGH = 8'd255;

	typedef logic [PIX_W-1:0]  pix_t;
	typedef logic [PROD_W-1:0] prod_t;

endpackage

`default_nettype wire

// File: rtl/gray_ordered_dither_top.sv
`default_nettype none

// Channel   Direction  Handshake                    Payload
// s_axis    in         s_axis_tvalid/s_axis_tready  tdata: blue, green, red; tuser: frame_start
// m_axis    out        m_axis_tvalid/m_axis_tready  tdata: gray_value, dither_value
// cfg       in         cfg_we (no wait)             cfg_index, cfg_wdata
//
// Each accepted pixel passes both stages before its result is valid, and one pixel can be
// accepted in every cycle while the output is not stalled: the first stage registers the
// three constant products and the matrix threshold, the second adds, compares and holds
// the result for the consumer. The position counters advance at acceptance, so pixels
// follow each other back to back. A stalled output only stops the pipeline once both
// stages hold a request; until then new pixels are still taken in.
// Reset (arst_n low) empties the pipeline, clears the position and restores the registers.
module gray_ordered_dither_top #(
	parameter int unsigned MAX_WIDTH = 1024
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       s_axis_tvalid,
	output logic                      s_axis_tready,
	input  wire  [23:0]               s_axis_tdata,  // blue [7:0], green [15:8], red [23:16]
	input  wire  [0:0]                s_axis_tuser,  // frame_start [0]
	output logic                      m_axis_tvalid,
	input  wire                       m_axis_tready,
	output logic [15:0]               m_axis_tdata,  // gray_value [7:0], dither_value [15:8]
	input  wire                       cfg_we,
	input  wire  [grod_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire  [grod_pkg::TH_W-1:0] cfg_wdata
);
	import grod_pkg::*;

	// Column counter holds 0 .. MAX_WIDTH-1; the compare is wide enough for both the
	// configured width and MAX_WIDTH itself.
	localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
	localparam int unsigned CMP_W  = (COL_W + 1 > WIDTH_W + 1) ? COL_W + 1 : WIDTH_W + 1;

	// Configuration registers.
	logic [WIDTH_W-1:0] image_width_q;
	logic [TH_W-1:0]    th01_q;
	logic [TH_W-1:0]    th23_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= RESET_WIDTH;
			th01_q        <= RESET_TH01;
			th23_q        <= RESET_TH23;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_IMAGE_WIDTH: image_width_q <= cfg_wdata[WIDTH_W-1:0];
				REG_TH_ROWS_0_1: th01_q        <= cfg_wdata;
				REG_TH_ROWS_2_3: th23_q        <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// Pipeline flow control.
	logic valid_s1;
	logic ready_s1;
	logic ready_s2;
	logic in_acc;

	assign ready_s2      = !m_axis_tvalid || m_axis_tready;
	assign ready_s1      = !valid_s1 || ready_s2;
	assign s_axis_tready = ready_s1;
	assign in_acc        = s_axis_tvalid && ready_s1;

	// Position within the frame. A frame start clears it before the pixel uses it.
	logic [COL_W-1:0] col_q;
	logic [1:0]       row_q;
	logic [COL_W-1:0] col_cur;
	logic [1:0]       row_cur;
	logic [CMP_W-1:0] width_eff;
	logic [CMP_W-1:0] col_next_wide;
	logic             row_wrap;

	assign col_cur = s_axis_tuser[0] ? '0 : col_q;
	assign row_cur = s_axis_tuser[0] ? 2'd0 : row_q;

	// A width of zero acts as one; anything above MAX_WIDTH acts as MAX_WIDTH.
	always_comb begin
		width_eff = CMP_W'(image_width_q);
		if (image_width_q == '0) begin
			width_eff = CMP_W'(1);
		end else if (CMP_W'(image_width_q) > CMP_W'(MAX_WIDTH)) begin
			width_eff = CMP_W'(MAX_WIDTH);
		end
	end

	assign col_next_wide = CMP_W'(col_cur) + CMP_W'(1);
	assign row_wrap      = col_next_wide >= width_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= 2'd0;
		end else if (in_acc) begin
			if (row_wrap) begin
				col_q <= '0;
				row_q <= row_cur + 2'd1;
			end else begin
				col_q <= col_next_wide[COL_W-1:0];
				row_q <= row_cur;
			end
		end
	end

	// Threshold for this pixel: rows 0-1 in one word, rows 2-3 in the other, byte
	// (row mod 2) * 4 + (column mod 4).
	logic [TH_W-1:0] th_word;
	logic [2:0]      th_byte;
	pix_t            th_cur;

	assign th_word = row_cur[1] ? th23_q : th01_q;
	assign th_byte = {row_cur[0], col_cur[1:0]};
	assign th_cur  = th_word[{th_byte, 3'b000} +: PIX_W];

	// Stage 1: constant products and the threshold.
	prod_t prod_b_s1;
	prod_t prod_g_s1;
	prod_t prod_r_s1;
	pix_t  th_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			prod_b_s1 <= PROD_W'(s_axis_tdata[7:0])   * PROD_W'(WEIGHT_BLUE);
			prod_g_s1 <= PROD_W'(s_axis_tdata[15:8])  * PROD_W'(WEIGHT_GREEN);
			prod_r_s1 <= PROD_W'(s_axis_tdata[23:16]) * PROD_W'(WEIGHT_RED);
			th_s1     <= th_cur;
		end
	end

	// Stage 2: sum, truncate to gray, compare. The weights add up to 65535, so the sum
	// always fits in 24 bits.
	prod_t luma_sum;
	pix_t  gray;
	pix_t  gray_s2;
	pix_t  dither_s2;

	assign luma_sum = prod_b_s1 + prod_g_s1 + prod_r_s1;
	assign gray     = luma_sum[PROD_W-1 -: PIX_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (ready_s2) begin
			m_axis_tvalid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			gray_s2   <= gray;
			dither_s2 <= (gray < th_s1) ? DITHER_LOW : DITHER_HIGH;
		end
	end

	assign m_axis_tdata = {dither_s2, gray_s2};

	// A result is either black or white.
	a_dither_binary: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (dither_s2 == DITHER_LOW || dither_s2 == DITHER_HIGH))
		else $error("dither value is neither 0 nor 255");

	// Truncated luma never reaches full scale.
	a_gray_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (gray_s2 != 8'hFF))
		else $error("gray value reached 255");

	// The column counter stays below the largest row length.
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		CMP_W'(col_q) < CMP_W'(MAX_WIDTH))
		else $error("column counter out of range");

	// After a frame start the position sits on the second pixel of the frame.
	a_frame_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && s_axis_tuser[0]) |=>
			((row_q == 2'd0 && col_q == COL_W'(1)) || (row_q == 2'd1 && col_q == '0)))
		else $error("position not restarted by frame start");

	// A new result only appears when stage 1 held a request.
	a_out_from_s1: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(valid_s1))
		else $error("result appeared without a request in stage 1");

endmodule

`default_nettype wire
